// ----- sv/clr_pkg.sv -----
// ----------------------------------------------------------------------------
// Color line rasterizer package
// Shared widths, input function codes and the sequencer state type.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Fixed field widths of the frame buffer interface.
  localparam int ROW_BITS   = 10;
  localparam int ADDR_BITS  = 20;
  localparam int COLOR_BITS = 32;
  localparam int CHANNELS   = 4;
  localparam int CHAN_BITS  = 8;
  localparam int CHAN_IDX_BITS = 2;

  // Row width after reset.
  localparam logic [ROW_BITS-1:0] ROW_WIDTH_RESET = 10'd512;

  // Input function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RUN
  } clr_state_t;

endpackage

// ----- sv/clr_div.sv -----
// ----------------------------------------------------------------------------
// Color line rasterizer divider
// Restoring unsigned divider, one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module clr_div #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvsr;
  logic [CNT_BITS-1:0]      cnt;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, quo[DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dvsr};
    fits  = trial >= {1'b0, dvsr};
  end

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shifts in from the bottom as the dividend leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- sv/color_interpolated_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Color interpolated line rasterizer
// All-octant Bresenham line stepper with linear per-channel color blending.
// ----------------------------------------------------------------------------
// A start transaction loads two endpoints and two RGBA colors; the block then
// holds in_stall high while one shared serial divider works out the color
// step of each of the four channels in turn, one quotient bit per cycle. A
// start on a single-point line needs no division and arms the line directly.
// Each tick transaction after that emits one pixel, with its coordinates,
// color, frame buffer byte address and a last flag; a tick while no line is
// armed is taken and emits nothing. The output register lets the next tick be
// taken in the same cycle the previous pixel is taken. The row width register
// must only be written while the block is idle.
module color_interpolated_line_rasterizer #(
  parameter int COORD_BITS = 9,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [clr_pkg::ROW_BITS-1:0]     cfg_write_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [COORD_BITS-1:0]            start_x,
  input  logic [COORD_BITS-1:0]            start_y,
  input  logic [COORD_BITS-1:0]            end_x,
  input  logic [COORD_BITS-1:0]            end_y,
  input  logic [clr_pkg::COLOR_BITS-1:0]   start_color,
  input  logic [clr_pkg::COLOR_BITS-1:0]   end_color,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_BITS-1:0]            pixel_x,
  output logic [COORD_BITS-1:0]            pixel_y,
  output logic [clr_pkg::COLOR_BITS-1:0]   pixel_color,
  output logic [clr_pkg::ADDR_BITS-1:0]    byte_address,
  output logic                             last
);

  import clr_pkg::*;

  localparam int DEC_BITS  = COORD_BITS + 2;
  localparam int ERR_BITS  = COORD_BITS + 3;
  localparam int QUO_BITS  = FRAC_BITS + CHAN_BITS;
  localparam int ACC_BITS  = FRAC_BITS + CHAN_BITS + 1;
  localparam int PROD_BITS = ROW_BITS + COORD_BITS + 1;
  localparam int LIN_BITS  = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

  clr_state_t state;
  clr_state_t state_next;

  logic [ROW_BITS-1:0]        row_width;
  logic [COORD_BITS-1:0]      cur_x;
  logic [COORD_BITS-1:0]      cur_y;
  logic                       x_dir;
  logic                       y_dir;
  logic [COORD_BITS-1:0]      abs_dx;
  logic [COORD_BITS-1:0]      abs_dy;
  logic signed [DEC_BITS-1:0] decision;
  logic [COORD_BITS-1:0]      steps_left;
  logic signed [ACC_BITS-1:0] color_accum [CHANNELS];
  logic signed [ACC_BITS-1:0] color_step [CHANNELS];
  logic [COLOR_BITS-1:0]      final_color;
  logic [CHAN_IDX_BITS-1:0]   chan;
  logic                       div_neg;

  // Handshake and sequencer controls.
  logic in_accept;
  logic start_acc;
  logic tick_acc;
  logic div_start;
  logic div_busy;
  logic div_done;
  logic [QUO_BITS-1:0] div_quotient;

  // Start geometry.
  logic                  x_dir_in;
  logic                  y_dir_in;
  logic [COORD_BITS-1:0] dx_in;
  logic [COORD_BITS-1:0] dy_in;
  logic [COORD_BITS-1:0] n_in;

  // Divider operands for the current channel.
  logic [CHAN_BITS-1:0] s_byte;
  logic [CHAN_BITS-1:0] e_byte;
  logic [CHAN_BITS-1:0] diff_mag;
  logic                 diff_neg;

  // Bresenham step terms.
  logic signed [ERR_BITS-1:0] e2;
  logic                       step_x;
  logic                       step_y;
  logic signed [DEC_BITS-1:0] decision_next;

  // Pixel terms.
  logic [COLOR_BITS-1:0] blend_color;
  logic [LIN_BITS-1:0]   lin_addr;

  // Accepted transactions; a tick only counts while a line is armed.
  assign in_stall  = (state == ST_DIV_START) || (state == ST_DIV_WAIT) ||
                     (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign start_acc = in_accept && (func == FUNC_START);
  assign tick_acc  = in_accept && (func == FUNC_TICK) && (state == ST_RUN);

  // Line geometry of a start transaction.
  always_comb begin
    x_dir_in = end_x < start_x;
    y_dir_in = end_y < start_y;
    dx_in    = x_dir_in ? start_x - end_x : end_x - start_x;
    dy_in    = y_dir_in ? start_y - end_y : end_y - start_y;
    n_in     = (dx_in > dy_in) ? dx_in : dy_in;
  end

  // Color difference of the channel being divided.
  always_comb begin
    s_byte   = color_accum[chan][FRAC_BITS +: CHAN_BITS];
    e_byte   = final_color[chan*CHAN_BITS +: CHAN_BITS];
    diff_neg = e_byte < s_byte;
    diff_mag = diff_neg ? s_byte - e_byte : e_byte - s_byte;
  end

  // Bresenham error update for one pixel step.
  always_comb begin
    e2     = $signed({decision, 1'b0});
    step_x = e2 > -$signed({3'b000, abs_dy});
    step_y = e2 < $signed({3'b000, abs_dx});
    decision_next = decision;
    if (step_x) begin
      decision_next = decision_next - $signed({2'b00, abs_dy});
    end
    if (step_y) begin
      decision_next = decision_next + $signed({2'b00, abs_dx});
    end
  end

  // Packed color from the accumulators; a negative channel reads as zero.
  // The accumulator stays between the two endpoint bytes, so it never
  // reaches past one byte of integer part.
  always_comb begin
    blend_color = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (color_accum[ch][ACC_BITS-1]) begin
        blend_color[ch*CHAN_BITS +: CHAN_BITS] = '0;
      end else begin
        blend_color[ch*CHAN_BITS +: CHAN_BITS] =
          color_accum[ch][FRAC_BITS +: CHAN_BITS];
      end
    end
  end

  // Linear pixel index of the current position.
  assign lin_addr = LIN_BITS'(row_width) * LIN_BITS'(cur_y) + LIN_BITS'(cur_x);

  // Sequencer next state and divider kick.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_acc) begin
          state_next = (n_in == '0) ? ST_RUN : ST_DIV_START;
        end
      end
      ST_RUN: begin
        if (start_acc) begin
          state_next = (n_in == '0) ? ST_RUN : ST_DIV_START;
        end else if (tick_acc && (steps_left == '0)) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (chan == CHAN_IDX_BITS'(CHANNELS - 1)) ? ST_RUN : ST_DIV_START;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and row width register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_width <= ROW_WIDTH_RESET;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        row_width <= cfg_write_data;
      end
    end
  end

  // Line state: loaded on start, advanced on each tick before the last.
  always_ff @(posedge clk) begin
    if (start_acc) begin
      x_dir       <= x_dir_in;
      y_dir       <= y_dir_in;
      abs_dx      <= dx_in;
      abs_dy      <= dy_in;
      decision    <= $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
      steps_left  <= n_in;
      cur_x       <= start_x;
      cur_y       <= start_y;
      final_color <= end_color;
      chan        <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        color_accum[ch] <= $signed({1'b0, start_color[ch*CHAN_BITS +: CHAN_BITS],
                                    {FRAC_BITS{1'b0}}});
        color_step[ch]  <= '0;
      end
    end else if (tick_acc && (steps_left != '0)) begin
      decision   <= decision_next;
      steps_left <= steps_left - 1'b1;
      if (step_x) begin
        cur_x <= x_dir ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (step_y) begin
        cur_y <= y_dir ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
        color_accum[ch] <= color_accum[ch] + color_step[ch];
      end
    end else begin
      // Color step setup, one channel per divider run.
      if (div_start) begin
        div_neg <= diff_neg;
      end
      if ((state == ST_DIV_WAIT) && div_done) begin
        color_step[chan] <= div_neg ? -$signed(ACC_BITS'(div_quotient))
                                    : $signed(ACC_BITS'(div_quotient));
        chan <= chan + 1'b1;
      end
    end
  end

  // Output register, freed when the pixel is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      pixel_x      <= cur_x;
      pixel_y      <= cur_y;
      pixel_color  <= (steps_left == '0) ? final_color : blend_color;
      byte_address <= {lin_addr[ADDR_BITS-3:0], 2'b00};
      last         <= steps_left == '0;
    end
  end

  // Shared divider for the four color steps.
  clr_div #(
    .DIVIDEND_BITS(QUO_BITS),
    .DIVISOR_BITS (COORD_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({diff_mag, {FRAC_BITS{1'b0}}}),
    .divisor (steps_left),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quotient)
  );

  // The block takes nothing while the color steps are being divided.
  a_stall_in_div: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV_START) || (state == ST_DIV_WAIT)) |-> in_stall)
    else $error("input taken during color step division");

  // The divider only reports a result while the sequencer waits for one.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  // The divider is quiet while pixels are stepped.
  a_div_idle_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !div_busy)
    else $error("divider busy while the line is armed");

  // A tick on an armed line always loads a pixel transaction.
  a_tick_emits: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> out_valid)
    else $error("accepted tick produced no pixel");

  // The last pixel disarms the line.
  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && (steps_left == '0)) |=> (state == ST_IDLE) && last)
    else $error("line still armed after its last pixel");

endmodule
